// ----- src/asd_pkg.sv -----
// Shared constants and types for the acceleration step detector.
package asd_pkg;

    // Depth of the magnitude averaging ring
    localparam int RING_DEPTH  = 5;
    localparam int POS_W       = $clog2(RING_DEPTH);
    localparam int SUM_W       = 16 + $clog2(RING_DEPTH);
    localparam int CMP_W       = SUM_W + 1;

    // Configuration register indexes
    localparam logic [1:0] CFG_STEP_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_MIN_STEP_GAP   = 2'd1;
    localparam logic [1:0] CFG_PEAK_WINDOW    = 2'd2;

    // Configuration reset values
    localparam logic [15:0] RST_STEP_THRESHOLD = 16'd492;
    localparam logic [15:0] RST_MIN_STEP_GAP   = 16'd400;
    localparam logic [15:0] RST_PEAK_WINDOW    = 16'd2000;

    // Unsigned Q4.12 magnitude
    typedef logic [15:0] q412_t;

endpackage

// ----- src/accel_step_detector.sv -----
// Step detector: iterative magnitude, ring mean in memory, step and peak tracking.
// A sample passes through squaring x, y and z in turn on one shared multiplier, 16
// square-root iterations of two radicand bits each, a sum state and a finish
// state that holds while the output register is full; no new sample is taken
// until its result is registered. A reset command goes straight to finish.
// Reset: synchronous active low; clears control state, counts, timers and
// configuration to defaults. The ring memory is not cleared.
module accel_step_detector (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_addr,
    input  logic [15:0]          cfg_wdata,
    // input channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_command,
    input  logic signed [15:0]   s_accel_x,
    input  logic signed [15:0]   s_accel_y,
    input  logic signed [15:0]   s_accel_z,
    input  logic [31:0]          s_now_ms,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_step_detected,
    output logic [15:0]          m_step_total,
    output asd_pkg::q412_t       m_sample_magnitude,
    output asd_pkg::q412_t       m_window_peak,
    output logic                 m_ring_full
);
    import asd_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SQUARE = 3'd1;
    localparam logic [2:0] ST_ROOT   = 3'd2;
    localparam logic [2:0] ST_SUM    = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(RING_DEPTH - 1);

    // configuration
    logic [15:0] thr_reg, gap_reg, pwin_reg;

    // control
    logic [2:0]  state_reg;
    logic [1:0]  sq_cnt_reg;
    logic [3:0]  it_cnt_reg;

    // captured item
    logic               cmd_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic [31:0]        now_reg;

    // datapath
    logic [31:0] sumsq_reg;
    logic [31:0] rad_reg;
    logic [19:0] rem_reg;
    q412_t       root_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] magw_reg;

    // ring memory and its read port
    q412_t ring_mem [RING_DEPTH];
    q412_t ring_rd_reg;

    // persistent detector state
    logic [POS_W-1:0] pos_reg;
    logic             filled_reg;
    logic [15:0]      tally_reg;
    logic [31:0]      last_step_reg;
    logic [31:0]      pwin_start_reg;
    q412_t            peak_reg;

    // output register
    logic  m_valid_reg;
    logic  o_step_reg, o_full_reg;
    logic [15:0] o_total_reg;
    q412_t o_mag_reg, o_peak_reg;

    logic in_xfer, out_free;
    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Square one axis per cycle on the shared multiplier
    logic signed [15:0] sq_op;
    logic signed [31:0] sq_prod;
    always_comb begin
        case (sq_cnt_reg)
            2'd0:    sq_op = ax_reg;
            2'd1:    sq_op = ay_reg;
            default: sq_op = az_reg;
        endcase
        sq_prod = sq_op * sq_op;
    end

    // One restoring square-root iteration
    logic [19:0] rem_shift, rem_trial;
    logic        root_bit;
    always_comb begin
        rem_shift = {rem_reg[17:0], rad_reg[31:30]};
        rem_trial = {2'b00, root_reg, 2'b01};
        root_bit  = (rem_shift >= rem_trial);
    end

    // Ring sum update with the new magnitude
    logic [SUM_W-1:0] sum_calc, mag_ext;
    always_comb begin
        mag_ext = SUM_W'(root_reg);
        if (filled_reg) begin
            sum_calc = sum_reg - SUM_W'(ring_rd_reg) + mag_ext;
        end else if (pos_reg == '0) begin
            sum_calc = mag_ext;
        end else begin
            sum_calc = sum_reg + mag_ext;
        end
    end

    // Step and peak decisions
    logic [CMP_W-1:0] limit;
    logic             filled_upd, step_hit;
    logic [POS_W-1:0] pos_upd;
    logic [31:0]      gap_diff, pwin_diff;
    logic             pwin_over;
    q412_t            peak_base, peak_upd;
    logic [15:0]      tally_upd;
    always_comb begin
        limit      = CMP_W'(sum_reg) + CMP_W'(thr_reg) * CMP_W'(RING_DEPTH);
        filled_upd = filled_reg || (pos_reg == POS_LAST);
        pos_upd    = (pos_reg == POS_LAST) ? '0 : pos_reg + POS_W'(1);
        gap_diff   = now_reg - last_step_reg;
        step_hit   = filled_upd && (CMP_W'(magw_reg) > limit)
                     && (gap_diff > {16'd0, gap_reg});
        tally_upd  = (step_hit && tally_reg != 16'hFFFF) ? tally_reg + 16'd1 : tally_reg;
        pwin_diff  = now_reg - pwin_start_reg;
        pwin_over  = (pwin_diff >= {16'd0, pwin_reg});
        peak_base  = pwin_over ? '0 : peak_reg;
        peak_upd   = (root_reg > peak_base) ? root_reg : peak_base;
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= RST_STEP_THRESHOLD;
            gap_reg  <= RST_MIN_STEP_GAP;
            pwin_reg <= RST_PEAK_WINDOW;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_STEP_THRESHOLD: thr_reg  <= cfg_wdata;
                CFG_MIN_STEP_GAP:   gap_reg  <= cfg_wdata;
                CFG_PEAK_WINDOW:    pwin_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Ring memory: read old entry at the write position, write on a sample's finish
    always_ff @(posedge aclk) begin
        ring_rd_reg <= ring_mem[pos_reg];
        if (state_reg == ST_FINISH && out_free && !cmd_reg) begin
            ring_mem[pos_reg] <= root_reg;
        end
    end

    // Datapath registers without reset
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            cmd_reg <= s_command;
            ax_reg  <= s_accel_x;
            ay_reg  <= s_accel_y;
            az_reg  <= s_accel_z;
            now_reg <= s_now_ms;
            sumsq_reg <= '0;
        end
        if (state_reg == ST_SQUARE) begin
            sumsq_reg <= sumsq_reg + 32'(sq_prod);
            if (sq_cnt_reg == 2'd2) begin
                rad_reg  <= sumsq_reg + 32'(sq_prod);
                rem_reg  <= '0;
                root_reg <= '0;
            end
        end
        if (state_reg == ST_ROOT) begin
            rad_reg  <= {rad_reg[29:0], 2'b00};
            rem_reg  <= root_bit ? rem_shift - rem_trial : rem_shift;
            root_reg <= {root_reg[14:0], root_bit};
        end
        if (state_reg == ST_SUM) begin
            sum_reg  <= sum_calc;
            magw_reg <= SUM_W'(root_reg) * SUM_W'(RING_DEPTH);
        end
        if (state_reg == ST_FINISH && out_free) begin
            if (cmd_reg) begin
                o_step_reg  <= 1'b0;
                o_total_reg <= '0;
                o_mag_reg   <= '0;
                o_peak_reg  <= peak_reg;
                o_full_reg  <= 1'b0;
            end else begin
                o_step_reg  <= step_hit;
                o_total_reg <= tally_upd;
                o_mag_reg   <= root_reg;
                o_peak_reg  <= peak_upd;
                o_full_reg  <= filled_upd;
            end
        end
    end

    // Sequencer and persistent state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            sq_cnt_reg     <= '0;
            it_cnt_reg     <= '0;
            pos_reg        <= '0;
            filled_reg     <= 1'b0;
            tally_reg      <= '0;
            last_step_reg  <= '0;
            pwin_start_reg <= '0;
            peak_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            // drop the result once transferred
            if (m_valid_reg && m_ready && state_reg != ST_FINISH) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        sq_cnt_reg <= '0;
                        state_reg  <= s_command ? ST_FINISH : ST_SQUARE;
                    end
                end
                ST_SQUARE: begin
                    sq_cnt_reg <= sq_cnt_reg + 2'd1;
                    if (sq_cnt_reg == 2'd2) begin
                        it_cnt_reg <= '0;
                        state_reg  <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    it_cnt_reg <= it_cnt_reg + 4'd1;
                    if (it_cnt_reg == 4'd15) begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    // hold until the output register is free
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                        if (cmd_reg) begin
                            tally_reg  <= '0;
                            pos_reg    <= '0;
                            filled_reg <= 1'b0;
                        end else begin
                            pos_reg    <= pos_upd;
                            filled_reg <= filled_upd;
                            tally_reg  <= tally_upd;
                            peak_reg   <= peak_upd;
                            if (step_hit) begin
                                last_step_reg <= now_reg;
                            end
                            if (pwin_over) begin
                                pwin_start_reg <= now_reg;
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_step_detected    = o_step_reg;
    assign m_step_total       = o_total_reg;
    assign m_sample_magnitude = o_mag_reg;
    assign m_window_peak      = o_peak_reg;
    assign m_ring_full        = o_full_reg;

    // One item in flight: no transfer right after a transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_ready)
        else $error("input taken while an item is in flight");

    // A step is only reported with a full ring
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_step_detected) |-> m_ring_full)
        else $error("step reported before ring filled");

    // The window peak covers the sample magnitude
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_window_peak >= m_sample_magnitude))
        else $error("window peak below sample magnitude");

    // Write position stays inside the ring
    assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_LAST)
        else $error("ring position out of range");

endmodule
